// ----- hdl/uartr_pkg.sv -----
`default_nettype none
package uartr_pkg;

    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_RX    = 2'd2;

    localparam logic [2:0] OFF_RBR = 3'd0;
    localparam logic [2:0] OFF_IER = 3'd1;
    localparam logic [2:0] OFF_IIR = 3'd2;
    localparam logic [2:0] OFF_LCR = 3'd3;
    localparam logic [2:0] OFF_MCR = 3'd4;
    localparam logic [2:0] OFF_LSR = 3'd5;
    localparam logic [2:0] OFF_MSR = 3'd6;
    localparam logic [2:0] OFF_SCR = 3'd7;

    localparam logic [7:0] LSR_DR   = 8'h01;
    localparam logic [7:0] LSR_OE   = 8'h02;
    localparam logic [7:0] LSR_ERR  = 8'h1E;
    localparam logic [7:0] LSR_BI   = 8'h10;
    localparam logic [7:0] LSR_THRE = 8'h20;
    localparam logic [7:0] LSR_TEMT = 8'h40;

    localparam logic [3:0] IIR_LINE  = 4'h6;
    localparam logic [3:0] IIR_TMO   = 4'hC;
    localparam logic [3:0] IIR_RXD   = 4'h4;
    localparam logic [3:0] IIR_THRE  = 4'h2;
    localparam logic [3:0] IIR_MODEM = 4'h0;
    localparam logic [3:0] IIR_NONE  = 4'h1;

    localparam logic [7:0] FCR_MASK = 8'hC1;
    localparam int unsigned TRIG_14 = 14;

    typedef struct packed {
        logic [3:0] ier;
        logic [7:0] lsr;
        logic       tmo;
        logic       rx_ready;
        logic       tx_pend;
        logic [3:0] msr_low;
    } t_eval_in;

    typedef struct packed {
        logic       raise;
        logic [3:0] ident;
    } t_eval_out;

endpackage
`default_nettype wire

// ----- hdl/uartr_ram.sv -----
`default_nettype none
module uartr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/uartr_irq_eval.sv -----
`default_nettype none
module uartr_irq_eval (
    input  wire uartr_pkg::t_eval_in  i_ev,
    output uartr_pkg::t_eval_out      o_ev
);
    import uartr_pkg::*;

    // fixed priority: line status, timeout, rx data, thr empty, modem
    always_comb begin
        o_ev.raise = 1'b1;
        if (i_ev.ier[2] && ((i_ev.lsr & LSR_ERR) != 8'h00)) begin
            o_ev.ident = IIR_LINE;
        end else if (i_ev.ier[0] && i_ev.tmo) begin
            o_ev.ident = IIR_TMO;
        end else if (i_ev.ier[0] && i_ev.rx_ready) begin
            o_ev.ident = IIR_RXD;
        end else if (i_ev.ier[1] && i_ev.tx_pend && ((i_ev.lsr & LSR_THRE) != 8'h00)) begin
            o_ev.ident = IIR_THRE;
        end else if (i_ev.ier[3] && (i_ev.msr_low != 4'h0)) begin
            o_ev.ident = IIR_MODEM;
        end else begin
            o_ev.ident = IIR_NONE;
            o_ev.raise = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/uart_16550_registers_unit.sv -----
`default_nettype none
// channel | dir | handshake            | payload
// s       | in  | i_s_tvalid/o_s_tready | tuser kind, tlast rx_last, tdata offset/data/rx byte
// m       | out | o_m_tvalid/i_m_tready | tdata read_data, tx_valid, tx_byte, irq, rx_accepted
// An item passes through accept, execute, drain check and finish; each byte that a drain
// moves from the receive store into the visible FIFO or holding register (up to
// FIFO_DEPTH bytes on a drain) adds a drain write and a return to the drain check.
// The result is registered in the finish step.
// Reset (synchronous, active low) clears the UART registers and pointers; the store
// needs no clearing. A new item is taken as soon as the previous one is finished, even
// while its result still waits in the output register; a held result stalls the next finish.
module uart_16550_registers_unit #(
    parameter int RX_CAPACITY = 256,
    parameter int FIFO_DEPTH  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,  // reg_offset[2:0], write_data[10:3], rx_byte[18:11]
    input  wire logic [1:0]  i_s_tuser,  // kind[1:0]
    input  wire logic        i_s_tlast,  // rx_last
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata   // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                         // irq[17], rx_accepted[18]
);
    import uartr_pkg::*;

    localparam int RAW = (RX_CAPACITY > 1) ? $clog2(RX_CAPACITY) : 1;
    localparam int CW  = $clog2(RX_CAPACITY + 1);
    localparam int VAW = $clog2(FIFO_DEPTH);
    localparam int VCW = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DRD, S_DWR, S_FIN} t_state;

    t_state         r_state;
    logic [7:0]     r_lcr, r_msr, r_lsr, r_fcr, r_dll, r_dlh, r_scr, r_hold;
    logic [3:0]     r_ier, r_iir;
    logic [4:0]     r_mcr;
    logic           r_txp, r_tmo;
    logic [RAW-1:0] r_rx_head;
    logic [CW-1:0]  r_rx_cnt;
    logic [VAW-1:0] r_vis_head;
    logic [VCW-1:0] r_vis_cnt;

    logic [1:0]     r_kind;
    logic [2:0]     r_off;
    logic [7:0]     r_wd, r_rb;
    logic           r_last;
    logic [7:0]     r_res_rd, r_res_txb;
    logic           r_res_txv, r_res_acc;
    logic           r_do_drain, r_do_eval, r_eval2x, r_set_thre;
    logic           r_m_valid;
    logic [23:0]    r_m_data;

    logic [7:0]     rx_rdata, vis_rdata;
    logic           rx_we, vis_we;
    logic [RAW-1:0] rx_waddr;
    logic [VAW-1:0] vis_waddr;

    logic           fifo_on, dlab, full, drain_cond, rx_ready;
    logic [CW:0]    queued, rx_sum;
    logic [VCW:0]   vis_sum;
    logic [VCW-1:0] trig;
    logic [RAW-1:0] rx_head_inc;
    logic [VAW-1:0] vis_head_inc;
    logic [7:0]     msr_old, msr_new;
    logic [3:0]     delta;
    t_eval_in       ev_a_in, ev_b_in;
    t_eval_out      ev_a, ev_b;

    function automatic logic [7:0] msr_view(input logic [4:0] mcr, input logic [7:0] msr);
        logic [7:0] v;
        v = msr;
        if (mcr[4]) begin
            v = {mcr[3], mcr[2], mcr[0], mcr[1], msr[3:0]};
        end
        return v;
    endfunction

    assign fifo_on = r_fcr[0];
    assign dlab    = r_lcr[7];

    always_comb begin
        queued = {1'b0, r_rx_cnt} + (fifo_on ? (CW+1)'(r_vis_cnt) : (CW+1)'(r_lsr[0]));
        full   = (queued >= (CW+1)'(RX_CAPACITY));
        rx_sum = (CW+1)'(r_rx_head) + (CW+1)'(r_rx_cnt);
        if (rx_sum >= (CW+1)'(RX_CAPACITY)) begin
            rx_waddr = RAW'(rx_sum - (CW+1)'(RX_CAPACITY));
        end else begin
            rx_waddr = RAW'(rx_sum);
        end
        vis_sum = (VCW+1)'(r_vis_head) + (VCW+1)'(r_vis_cnt);
        if (vis_sum >= (VCW+1)'(FIFO_DEPTH)) begin
            vis_waddr = VAW'(vis_sum - (VCW+1)'(FIFO_DEPTH));
        end else begin
            vis_waddr = VAW'(vis_sum);
        end
        rx_head_inc  = (r_rx_head == RAW'(RX_CAPACITY - 1)) ? '0 : r_rx_head + 1'b1;
        vis_head_inc = (r_vis_head == VAW'(FIFO_DEPTH - 1)) ? '0 : r_vis_head + 1'b1;
        case (r_fcr[7:6])
            2'b01:   trig = VCW'(4);
            2'b10:   trig = VCW'(8);
            2'b11:   trig = VCW'(TRIG_14);
            default: trig = VCW'(1);
        endcase
        rx_ready = fifo_on ? ((r_vis_cnt != '0) && (r_vis_cnt >= trig)) : r_lsr[0];
        if (fifo_on) begin
            drain_cond = (r_rx_cnt != '0) && (r_vis_cnt < VCW'(FIFO_DEPTH));
        end else begin
            drain_cond = !r_lsr[0] && (r_rx_cnt != '0);
        end
        msr_old = msr_view(r_mcr, r_msr);
        msr_new = msr_view(r_wd[4:0], r_msr);
        delta   = {(msr_old[7] ^ msr_new[7]), (msr_old[6] & !msr_new[6]),
                   (msr_old[5] ^ msr_new[5]), (msr_old[4] ^ msr_new[4])};
        rx_we   = (r_state == S_EXEC) && !full &&
                  ((r_kind == K_RX) ||
                   ((r_kind == K_WRITE) && (r_off == OFF_RBR) && !dlab && r_mcr[4]));
        vis_we  = (r_state == S_DWR) && fifo_on;

        ev_a_in.ier      = r_ier;
        ev_a_in.lsr      = r_lsr;
        ev_a_in.tmo      = r_tmo;
        ev_a_in.rx_ready = rx_ready;
        ev_a_in.tx_pend  = r_txp;
        ev_a_in.msr_low  = r_msr[3:0];
        ev_b_in          = ev_a_in;
        if (r_set_thre) begin
            ev_b_in.lsr     = r_lsr | LSR_THRE | LSR_TEMT;
            ev_b_in.tx_pend = 1'b1;
        end
    end

    uartr_ram #(.DEPTH(RX_CAPACITY), .WIDTH(8), .AW(RAW)) u_rx_ram (
        .i_clk  (i_clk),
        .i_we   (rx_we),
        .i_waddr(rx_waddr),
        .i_wdata((r_kind == K_RX) ? r_rb : r_wd),
        .i_raddr(r_rx_head),
        .o_rdata(rx_rdata)
    );

    uartr_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(8), .AW(VAW)) u_vis_ram (
        .i_clk  (i_clk),
        .i_we   (vis_we),
        .i_waddr(vis_waddr),
        .i_wdata(rx_rdata),
        .i_raddr(r_vis_head),
        .o_rdata(vis_rdata)
    );

    uartr_irq_eval u_eval_a (.i_ev(ev_a_in), .o_ev(ev_a));
    uartr_irq_eval u_eval_b (.i_ev(ev_b_in), .o_ev(ev_b));

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lcr      <= '0;
            r_ier      <= '0;
            r_mcr      <= '0;
            r_msr      <= '0;
            r_lsr      <= LSR_THRE | LSR_TEMT;
            r_fcr      <= '0;
            r_iir      <= IIR_NONE;
            r_dll      <= '0;
            r_dlh      <= '0;
            r_scr      <= '0;
            r_hold     <= '0;
            r_txp      <= 1'b0;
            r_tmo      <= 1'b0;
            r_rx_head  <= '0;
            r_rx_cnt   <= '0;
            r_vis_head <= '0;
            r_vis_cnt  <= '0;
            r_m_valid  <= 1'b0;
            r_do_drain <= 1'b0;
            r_do_eval  <= 1'b0;
            r_eval2x   <= 1'b0;
            r_set_thre <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_kind     <= i_s_tuser;
                        r_off      <= i_s_tdata[2:0];
                        r_wd       <= i_s_tdata[10:3];
                        r_rb       <= i_s_tdata[18:11];
                        r_last     <= i_s_tlast;
                        r_res_rd   <= '0;
                        r_res_txv  <= 1'b0;
                        r_res_txb  <= '0;
                        r_res_acc  <= 1'b0;
                        r_do_drain <= 1'b0;
                        r_do_eval  <= 1'b0;
                        r_eval2x   <= 1'b0;
                        r_set_thre <= 1'b0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_kind)
                        K_READ: begin
                            case (r_off)
                                OFF_RBR: begin
                                    if (dlab) begin
                                        r_res_rd <= r_dll;
                                    end else begin
                                        if (fifo_on) begin
                                            if (r_vis_cnt != '0) begin
                                                r_res_rd   <= vis_rdata;
                                                r_vis_head <= vis_head_inc;
                                                r_vis_cnt  <= r_vis_cnt - 1'b1;
                                            end
                                        end else if (r_lsr[0]) begin
                                            r_res_rd <= r_hold;
                                            r_lsr    <= r_lsr & ~LSR_DR;
                                        end
                                        r_tmo      <= 1'b0;
                                        r_do_drain <= 1'b1;
                                        r_do_eval  <= 1'b1;
                                    end
                                end
                                OFF_IER: r_res_rd <= dlab ? r_dlh : {4'h0, r_ier};
                                OFF_IIR: begin
                                    r_res_rd <= {(fifo_on ? 2'b11 : 2'b00), 2'b00, r_iir};
                                    if (r_iir == IIR_THRE) begin
                                        r_txp     <= 1'b0;
                                        r_do_eval <= 1'b1;
                                    end
                                end
                                OFF_LCR: r_res_rd <= r_lcr;
                                OFF_MCR: r_res_rd <= {3'b000, r_mcr};
                                OFF_LSR: begin
                                    r_res_rd <= r_lsr;
                                    if ((r_lsr & LSR_ERR) != 8'h00) begin
                                        r_lsr     <= r_lsr & ~LSR_ERR;
                                        r_do_eval <= 1'b1;
                                    end
                                end
                                OFF_MSR: begin
                                    r_res_rd  <= msr_old;
                                    r_msr     <= {r_msr[7:4], 4'h0};
                                    r_do_eval <= 1'b1;
                                end
                                default: r_res_rd <= r_scr;
                            endcase
                        end
                        K_WRITE: begin
                            case (r_off)
                                OFF_RBR: begin
                                    if (dlab) begin
                                        r_dll <= r_wd;
                                    end else begin
                                        if (r_mcr[4]) begin
                                            // loopback: byte goes back into the receiver
                                            r_lsr <= (r_lsr & ~(LSR_THRE | LSR_TEMT)) |
                                                     (full ? LSR_OE : 8'h00);
                                            if (!full) begin
                                                r_rx_cnt <= r_rx_cnt + 1'b1;
                                            end
                                            r_do_drain <= 1'b1;
                                            r_eval2x   <= 1'b1;
                                        end else begin
                                            r_res_txv <= 1'b1;
                                            r_res_txb <= r_wd;
                                        end
                                        r_set_thre <= 1'b1;
                                        r_do_eval  <= 1'b1;
                                    end
                                end
                                OFF_IER: begin
                                    if (dlab) begin
                                        r_dlh <= r_wd;
                                    end else begin
                                        r_ier <= r_wd[3:0];
                                        if (r_ier[1] != r_wd[1]) begin
                                            r_txp <= r_wd[1] & r_lsr[5];
                                        end
                                        r_do_eval <= 1'b1;
                                    end
                                end
                                OFF_IIR: begin
                                    r_fcr <= r_wd & FCR_MASK;
                                    if (r_wd[1]) begin
                                        r_vis_head <= '0;
                                        r_vis_cnt  <= '0;
                                        r_rx_head  <= '0;
                                        r_rx_cnt   <= '0;
                                        r_hold     <= '0;
                                        r_tmo      <= 1'b0;
                                        r_lsr      <= r_lsr & ~(LSR_DR | LSR_ERR);
                                    end else begin
                                        r_do_drain <= 1'b1;
                                    end
                                    r_set_thre <= r_wd[2];
                                    r_do_eval  <= 1'b1;
                                end
                                OFF_LCR: begin
                                    r_lcr <= r_wd;
                                    if (r_wd[6] && !r_lcr[6]) begin
                                        r_lsr  <= r_lsr | LSR_BI | LSR_DR;
                                        r_hold <= '0;
                                    end
                                    r_do_eval <= 1'b1;
                                end
                                OFF_MCR: begin
                                    r_mcr     <= r_wd[4:0];
                                    r_msr     <= {msr_new[7:4], r_msr[3:0] | delta};
                                    r_do_eval <= 1'b1;
                                end
                                OFF_SCR: r_scr <= r_wd;
                                default: ;
                            endcase
                        end
                        K_RX: begin
                            if (full) begin
                                r_lsr <= r_lsr | LSR_OE;
                            end else begin
                                r_rx_cnt  <= r_rx_cnt + 1'b1;
                                r_res_acc <= 1'b1;
                            end
                            r_do_drain <= r_last;
                            r_do_eval  <= r_last;
                        end
                        default: ;
                    endcase
                    r_state <= S_DRD;
                end
                S_DRD: begin
                    if (r_do_drain && drain_cond) begin
                        r_state <= S_DWR;
                    end else begin
                        if (r_do_drain) begin
                            if (fifo_on) begin
                                r_lsr[0] <= (r_vis_cnt != '0);
                                r_tmo    <= (r_vis_cnt != '0) && (r_vis_cnt < trig);
                            end else begin
                                r_tmo <= 1'b0;
                            end
                        end
                        r_state <= S_FIN;
                    end
                end
                S_DWR: begin
                    if (fifo_on) begin
                        r_vis_cnt <= r_vis_cnt + 1'b1;
                    end else begin
                        r_hold   <= rx_rdata;
                        r_lsr[0] <= 1'b1;
                    end
                    r_rx_head <= rx_head_inc;
                    r_rx_cnt  <= r_rx_cnt - 1'b1;
                    r_state   <= S_DRD;
                end
                S_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        if (r_set_thre) begin
                            r_lsr <= r_lsr | LSR_THRE | LSR_TEMT;
                            r_txp <= 1'b1;
                        end
                        if (r_do_eval) begin
                            r_iir <= ev_b.ident;
                        end
                        r_m_data  <= {5'b00000, r_res_acc,
                                      (r_eval2x & ev_a.raise) | (r_do_eval & ev_b.raise),
                                      r_res_txb, r_res_txv, r_res_rd};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
